[design/mqmr_pkg.sv]
package mqmr_pkg;

  localparam int QUEUES        = 4;
  localparam int SLOTS         = 8;
  localparam int MESSAGE_BYTES = 32;

  localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PW  = $clog2(SLOTS);
  localparam int IW  = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
  localparam int CW  = $clog2(MESSAGE_BYTES + 1);
  localparam int BAW = QW + PW + IW;
  localparam int LAW = QW + PW;
  localparam int BYTE_DEPTH = 1 << BAW;
  localparam int LEN_DEPTH  = 1 << LAW;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  localparam logic [1:0] DROP_NONE  = 2'd0;
  localparam logic [1:0] DROP_FULL  = 2'd1;
  localparam logic [1:0] DROP_TRUNC = 2'd2;

  typedef struct packed {
    logic push_acc;
    logic pop_acc;
    logic emit_byte;
    logic emit_okz;
  } mqmr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pop_empty;
    logic len_zero;
    logic byte_last;
  } mqmr_sts_t;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == PW'(SLOTS - 1)) ? '0 : p + PW'(1);
  endfunction

endpackage

[design/mqmr_ctrl.sv]
module mqmr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                action_i,
  input  mqmr_pkg::mqmr_sts_t sts_i,
  output logic                in_ready_o,
  output mqmr_pkg::mqmr_cmd_t cmd_o
);
  import mqmr_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_STREAM = 1'b1;

  logic state_q, state_d;

  always_comb begin
    in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
    cmd_o      = '0;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && sts_i.out_free) begin
          if (action_i == ACT_PUSH) begin
            cmd_o.push_acc = 1'b1;
          end else begin
            cmd_o.pop_acc = 1'b1;
            if (!sts_i.pop_empty) state_d = S_STREAM;
          end
        end
      end
      S_STREAM: begin
        if (sts_i.out_free) begin
          if (sts_i.len_zero) begin
            cmd_o.emit_okz = 1'b1;
            state_d        = S_IDLE;
          end else begin
            cmd_o.emit_byte = 1'b1;
            if (sts_i.byte_last) state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STREAM) |-> !in_ready_o)
    else $error("input accepted while a pop streams");
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.push_acc, cmd_o.pop_acc, cmd_o.emit_byte, cmd_o.emit_okz}))
    else $error("conflicting datapath commands");
  a_pop_starts_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop_acc && !sts_i.pop_empty) |=> (state_q == S_STREAM))
    else $error("nonempty pop did not start streaming");
  a_last_byte_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_byte && sts_i.byte_last) |=> (state_q == S_IDLE))
    else $error("stream did not end after last byte");
`endif

endmodule

[design/mqmr_dp.sv]
module mqmr_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mqmr_pkg::mqmr_cmd_t cmd_i,
  output mqmr_pkg::mqmr_sts_t sts_o,
  input  logic                action_i,
  input  logic [1:0]          queue_sel_i,
  input  logic [7:0]          data_in_i,
  input  logic                end_of_message_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          data_out_o,
  output logic [1:0]          status_o,
  output logic                last_o
);
  import mqmr_pkg::*;

  logic [PW-1:0] head_q [QUEUES];
  logic [PW-1:0] head_d [QUEUES];
  logic [PW-1:0] tail_q [QUEUES];
  logic [PW-1:0] tail_d [QUEUES];

  logic          push_open_q, push_open_d;
  logic [QW-1:0] push_queue_q, push_queue_d;
  logic [CW-1:0] push_count_q, push_count_d;
  logic [1:0]    push_drop_q, push_drop_d;

  logic [7:0]    byte_mem [BYTE_DEPTH];
  logic [CW-1:0] len_mem [LEN_DEPTH];
  logic [7:0]    byte_rd_q;
  logic [CW-1:0] len_rd_q;

  logic [QW-1:0] pop_queue_q;
  logic [PW-1:0] pop_head_q;
  logic [IW-1:0] idx_q;

  logic          out_valid_q;
  logic [7:0]    data_out_q;
  logic [1:0]    status_q;
  logic          last_q;

  logic [QW-1:0] sel;
  logic [QW-1:0] rq;
  logic [PW-1:0] h, t;
  logic          full, empty;
  logic [1:0]    drop_cur, drop_nxt;
  logic [CW-1:0] cnt_cur, cnt_nxt;
  logic          byte_wr, len_wr, commit, byte_rd;
  logic [BAW-1:0] byte_wr_addr, byte_rd_addr;
  logic [LAW-1:0] len_addr;
  logic [CW-1:0] len_clamp;
  logic [IW-1:0] idx_nxt;
  logic [1:0]    push_status;

  assign sel   = QW'(32'(queue_sel_i) % QUEUES);
  assign rq    = (action_i == ACT_PUSH && push_open_q) ? push_queue_q : sel;
  assign h     = head_q[rq];
  assign t     = tail_q[rq];
  assign full  = (next_slot(t) == h);
  assign empty = (h == t);

  always_comb begin
    drop_cur = push_open_q ? push_drop_q : (full ? DROP_FULL : DROP_NONE);
    cnt_cur  = push_open_q ? push_count_q : '0;
    drop_nxt = drop_cur;
    cnt_nxt  = cnt_cur;
    byte_wr  = 1'b0;
    if (drop_cur != DROP_FULL) begin
      if (cnt_cur < CW'(MESSAGE_BYTES)) begin
        byte_wr = cmd_i.push_acc;
        cnt_nxt = cnt_cur + CW'(1);
      end else begin
        drop_nxt = DROP_TRUNC;
      end
    end
    commit      = cmd_i.push_acc && end_of_message_i && (drop_nxt != DROP_FULL);
    len_wr      = commit;
    push_status = (drop_nxt == DROP_FULL)  ? ST_FULL :
                  (drop_nxt == DROP_TRUNC) ? ST_TRUNC : ST_OK;
  end

  assign byte_wr_addr = {rq, t, cnt_cur[IW-1:0]};
  assign len_addr     = {rq, (cmd_i.pop_acc ? h : t)};

  // Pop reads slot byte 0 at the accept, then prefetches the next byte on each emit.
  assign idx_nxt      = idx_q + IW'(1);
  assign byte_rd      = (cmd_i.pop_acc && !empty) || cmd_i.emit_byte;
  assign byte_rd_addr = cmd_i.pop_acc ? {sel, h, {IW{1'b0}}}
                                      : {pop_queue_q, pop_head_q, idx_nxt};

  assign len_clamp = (len_rd_q > CW'(MESSAGE_BYTES)) ? CW'(MESSAGE_BYTES) : len_rd_q;

  always_comb begin
    push_open_d  = push_open_q;
    push_queue_d = push_queue_q;
    push_count_d = push_count_q;
    push_drop_d  = push_drop_q;
    head_d       = head_q;
    tail_d       = tail_q;
    if (cmd_i.push_acc) begin
      if (end_of_message_i) begin
        push_open_d  = 1'b0;
        push_count_d = '0;
        push_drop_d  = DROP_NONE;
        if (commit) tail_d[rq] = next_slot(t);
      end else begin
        push_open_d  = 1'b1;
        push_queue_d = rq;
        push_count_d = cnt_nxt;
        push_drop_d  = drop_nxt;
      end
    end
    if (cmd_i.pop_acc && !empty) head_d[rq] = next_slot(h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      push_open_q  <= 1'b0;
      push_queue_q <= '0;
      push_count_q <= '0;
      push_drop_q  <= DROP_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      push_open_q  <= push_open_d;
      push_queue_q <= push_queue_d;
      push_count_q <= push_count_d;
      push_drop_q  <= push_drop_d;
      if ((cmd_i.push_acc && end_of_message_i) || (cmd_i.pop_acc && empty) ||
          cmd_i.emit_byte || cmd_i.emit_okz) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_wr) byte_mem[byte_wr_addr] <= data_in_i;
    if (byte_rd) byte_rd_q <= byte_mem[byte_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (len_wr) len_mem[len_addr] <= cnt_nxt;
    if (cmd_i.pop_acc && !empty) len_rd_q <= len_mem[len_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_acc) begin
      pop_queue_q <= sel;
      pop_head_q  <= h;
      idx_q       <= '0;
    end else if (cmd_i.emit_byte) begin
      idx_q <= idx_nxt;
    end
    if (cmd_i.push_acc && end_of_message_i) begin
      data_out_q <= '0;
      status_q   <= push_status;
      last_q     <= 1'b1;
    end else if (cmd_i.pop_acc && empty) begin
      data_out_q <= '0;
      status_q   <= ST_EMPTY;
      last_q     <= 1'b1;
    end else if (cmd_i.emit_okz) begin
      data_out_q <= '0;
      status_q   <= ST_OK;
      last_q     <= 1'b1;
    end else if (cmd_i.emit_byte) begin
      data_out_q <= byte_rd_q;
      status_q   <= ST_OK;
      last_q     <= sts_o.byte_last;
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.pop_empty = empty;
  assign sts_o.len_zero  = (len_clamp == '0);
  assign sts_o.byte_last = ((CW'(idx_q) + CW'(1)) == len_clamp);

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

[design/multi_queue_message_ring.sv]
// Push: a byte transfers while idle and the output register is free; the status of a
//   push is loaded into the output register at the edge that transfers its last byte.
// Pop: an empty pop loads its status at the transfer edge; a nonempty pop of N bytes loads
//   its first byte in the next cycle, then one byte per cycle while the output is taken, so
//   input is held off until its last byte has been loaded.
// Reset clears queue pointers and push state at once; the slot memories need no clearing.
module multi_queue_message_ring (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [1:0] queue_sel_i,
  input  logic [7:0] data_in_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  import mqmr_pkg::*;

  // Commands from the sequencer, status back from the queue datapath.
  mqmr_cmd_t cmd;
  mqmr_sts_t sts;

  // Sequencer: idle takes pushes and pops; a nonempty pop streams its bytes
  // out of the slot memory, one transfer per cycle while the output is free, before anything new is taken.
  mqmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // Datapath: head/tail pointers, open push state, byte and length memories
  // with registered reads, and the output register that holds a result
  // until it is transferred.
  mqmr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .queue_sel_i      (queue_sel_i),
    .data_in_i        (data_in_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_out_o       (data_out_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule
